// ===== rtl/cgt_pkg.sv =====
// Shared types, constants and elaboration-time tables for the color grade texel transform.
// Used by every design module of the block; no dependencies of its own.
`default_nettype none

package cgt_pkg;

  localparam int GRID_SIZE = 16;
  localparam int GRID_LIM  = GRID_SIZE - 1;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;
  localparam int LOG_FRAC  = 16;
  localparam int DIV_STEPS = 17;

  // pipeline depths, counted in register stages
  localparam int LAT_POINT  = 1;
  localparam int LAT_GRAD   = 3 + DIV_STEPS + 1;
  localparam int LAT_GAMMA  = 1 + LOG_FRAC + 1 + LOG_FRAC + 1;
  localparam int LAT_XFORM  = LAT_GAMMA;
  localparam int LAT_BLEND  = 2;
  localparam int PIPE_DEPTH = LAT_XFORM + LAT_BLEND;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_IDENTITY,
    MODE_TEMPERATURE,
    MODE_COLORIZE,
    MODE_GRADIENT,
    MODE_CONTRAST,
    MODE_GAMMA
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_AMOUNT,
    REG_COLOR_A,
    REG_COLOR_B,
    REG_TAP_LEVELS,
    REG_CONTRAST,
    REG_BRIGHTNESS,
    REG_GAMMA
  } reg_idx_t;

  typedef logic signed [15:0] chan_t;
  typedef chan_t [2:0] rgb_t;

  typedef struct packed {
    rgb_t t;
    logic sat;
  } tres_t;

  typedef struct packed {
    logic sat;
    chan_t v;
  } satv_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [12:0]        amount;
    logic [47:0]        color_a;
    logic [47:0]        color_b;
    logic [31:0]        tap_levels;
    logic [14:0]        contrast;
    logic signed [13:0] brightness;
    logic [13:0]        gamma;
  } cfg_t;

  function automatic satv_t sat_chan(input logic signed [39:0] x);
    satv_t res;
    if (x > 40'sd32767) begin
      res.sat = 1'b1;
      res.v   = 16'sh7fff;
    end else if (x < -40'sd32768) begin
      res.sat = 1'b1;
      res.v   = 16'sh8000;
    end else begin
      res.sat = 1'b0;
      res.v   = x[15:0];
    end
    return res;
  endfunction

  // identity ramp level for each grid index, rounded
  function automatic logic [GRID_SIZE*16-1:0] ident_table();
    logic [GRID_SIZE*16-1:0] tbl;
    tbl = '0;
    for (int k = 0; k < GRID_SIZE; k++) begin
      tbl[k*16 +: 16] = 16'((k * ONE * 2 + GRID_LIM) / (2 * GRID_LIM));
    end
    return tbl;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q1.30 factors 2^(2^(i-16)), entry i for fraction bit i
  function automatic logic [LOG_FRAC*32-1:0] exp_table();
    logic [LOG_FRAC*32-1:0] tbl;
    logic [63:0]            c;
    tbl = '0;
    c   = isqrt64(64'd2 << 60);
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      tbl[i*32 +: 32] = c[31:0];
      c = isqrt64(c << 30);
    end
    return tbl;
  endfunction

  localparam logic [GRID_SIZE*16-1:0] IDENT_TBL = ident_table();
  localparam logic [LOG_FRAC*32-1:0]  EXP_TBL   = exp_table();

endpackage

`default_nettype wire

// ===== rtl/color_grade_texel_transform_unit.sv =====
// Top level of the color grade texel transform: input stage, the three transform
// units, alignment delays and the blend. Depends on cgt_pkg and the cgt_* design modules.
//
//   port group   direction  handshake           payload
//   texel in     in         in_valid/in_stall   in_red in_green in_blue grid_x grid_y grid_z
//   result out   out        out_valid/out_stall out_red out_green out_blue saturated
//   config       in/out     psel/penable/pready paddr pwdata prdata (64-bit, 8-byte stride)
//
// One texel per clock unless a stalled result holds the pipeline. The depth
// is set by the gamma unit (16 squaring stages for the log, 16 multiply
// stages for the exp, plus normalize, scale and round).
// Synchronous reset empties the pipeline and loads the register defaults.
// A stalled result holds the whole pipeline, so in_stall follows out_stall
// while a result is waiting.
`default_nettype none

module color_grade_texel_transform_unit import cgt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [15:0] in_red,
  input  wire logic signed [15:0] in_green,
  input  wire logic signed [15:0] in_blue,
  input  wire logic [3:0]        grid_x,
  input  wire logic [3:0]        grid_y,
  input  wire logic [3:0]        grid_z,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [15:0]     out_red,
  output logic signed [15:0]     out_green,
  output logic signed [15:0]     out_blue,
  output logic                   saturated,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  cgt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic                  en;
  logic [PIPE_DEPTH:0]   vld;
  rgb_t                  src_pipe [LAT_XFORM+1];
  logic [2:0][IDX_W-1:0] idx_q;

  assign in_stall = vld[PIPE_DEPTH] && out_stall;
  assign en       = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_pipe[0] <= {in_blue, in_green, in_red};
      idx_q       <= {IDX_W'(grid_z), IDX_W'(grid_y), IDX_W'(grid_x)};
      for (int j = 0; j < LAT_XFORM; j++) begin
        src_pipe[j+1] <= src_pipe[j];
      end
    end
  end

  tres_t pt_res;
  tres_t gr_res;
  tres_t gm_res;
  chan_t gm_t   [3];
  logic  gm_sat [3];

  cgt_point u_point (
    .clk (clk),
    .en  (en),
    .src (src_pipe[0]),
    .idx (idx_q),
    .cfg (cfg),
    .res (pt_res)
  );

  cgt_grad u_grad (
    .clk (clk),
    .en  (en),
    .src (src_pipe[0]),
    .cfg (cfg),
    .res (gr_res)
  );

  for (genvar i = 0; i < 3; i++) begin : g_gamma
    cgt_gamma u_gamma (
      .clk   (clk),
      .en    (en),
      .x     (src_pipe[0][i]),
      .gamma (cfg.gamma),
      .t     (gm_t[i]),
      .sat   (gm_sat[i])
    );
  end

  always_comb begin
    gm_res.sat = gm_sat[0] | gm_sat[1] | gm_sat[2];
    for (int i = 0; i < 3; i++) begin
      gm_res.t[i] = gm_t[i];
    end
  end

  // align the shorter units with the gamma unit
  tres_t pt_dly [LAT_XFORM-LAT_POINT];
  tres_t gr_dly [LAT_XFORM-LAT_GRAD];

  always_ff @(posedge clk) begin
    if (en) begin
      pt_dly[0] <= pt_res;
      for (int j = 1; j < LAT_XFORM - LAT_POINT; j++) begin
        pt_dly[j] <= pt_dly[j-1];
      end
      gr_dly[0] <= gr_res;
      for (int j = 1; j < LAT_XFORM - LAT_GRAD; j++) begin
        gr_dly[j] <= gr_dly[j-1];
      end
    end
  end

  tres_t xf;

  always_comb begin
    case (mode_t'(cfg.mode))
      MODE_GRADIENT: xf = gr_dly[LAT_XFORM-LAT_GRAD-1];
      MODE_GAMMA:    xf = gm_res;
      default:       xf = pt_dly[LAT_XFORM-LAT_POINT-1];
    endcase
  end

  rgb_t out_rgb;

  cgt_blend u_blend (
    .clk    (clk),
    .en     (en),
    .src    (src_pipe[LAT_XFORM]),
    .xf     (xf),
    .amount (cfg.amount),
    .o      (out_rgb),
    .sat    (saturated)
  );

  assign out_valid = vld[PIPE_DEPTH];
  assign out_red   = out_rgb[0];
  assign out_green = out_rgb[1];
  assign out_blue  = out_rgb[2];

endmodule

`default_nettype wire

// ===== rtl/cgt_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on cgt_pkg for the register map and the cfg_t bundle.
`default_nettype none

module cgt_regs import cgt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= 3'(MODE_NONE);
      cfg.amount     <= 13'(ONE);
      cfg.color_a    <= 48'h1000_1000_1000;
      cfg.color_b    <= '0;
      cfg.tap_levels <= 32'h1000_0000;
      cfg.contrast   <= 15'(ONE);
      cfg.brightness <= '0;
      cfg.gamma      <= 14'(ONE);
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MODE:       cfg.mode       <= pwdata[2:0];
        REG_AMOUNT:     cfg.amount     <= pwdata[12:0];
        REG_COLOR_A:    cfg.color_a    <= pwdata[47:0];
        REG_COLOR_B:    cfg.color_b    <= pwdata[47:0];
        REG_TAP_LEVELS: cfg.tap_levels <= pwdata[31:0];
        REG_CONTRAST:   cfg.contrast   <= pwdata[14:0];
        REG_BRIGHTNESS: cfg.brightness <= pwdata[13:0];
        REG_GAMMA:      cfg.gamma      <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:       prdata = CFG_DW'(cfg.mode);
      REG_AMOUNT:     prdata = CFG_DW'(cfg.amount);
      REG_COLOR_A:    prdata = CFG_DW'(cfg.color_a);
      REG_COLOR_B:    prdata = CFG_DW'(cfg.color_b);
      REG_TAP_LEVELS: prdata = CFG_DW'(cfg.tap_levels);
      REG_CONTRAST:   prdata = CFG_DW'(cfg.contrast);
      REG_BRIGHTNESS: prdata = CFG_DW'(unsigned'(cfg.brightness));
      REG_GAMMA:      prdata = CFG_DW'(cfg.gamma);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cgt_point.sv =====
// Single-stage point operations: pass-through, identity ramp, gain and contrast.
// Depends on cgt_pkg for types, the identity table and the saturation helper.
`default_nettype none

module cgt_point import cgt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire rgb_t                  src,
  input  wire logic [2:0][IDX_W-1:0] idx,
  input  wire cfg_t                  cfg,
  output tres_t                      res
);

  tres_t              res_next;
  logic [IDX_W-1:0]   k     [3];
  logic [15:0]        ident [3];
  logic signed [32:0] gain_p [3];
  logic signed [16:0] cdiff [3];
  logic signed [32:0] con_p [3];
  logic signed [39:0] tv    [3];
  satv_t              sv    [3];

  always_comb begin
    res_next.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      k[i]      = (idx[i] > IDX_W'(GRID_LIM)) ? IDX_W'(GRID_LIM) : idx[i];
      ident[i]  = IDENT_TBL[k[i]*16 +: 16];
      gain_p[i] = $signed(src[i]) * $signed({1'b0, cfg.color_a[16*i +: 16]});
      cdiff[i]  = $signed({src[i][15], src[i]}) - 17'sd2048;
      con_p[i]  = cdiff[i] * $signed({1'b0, cfg.contrast});
      case (mode_t'(cfg.mode))
        MODE_IDENTITY:    tv[i] = 40'({1'b0, ident[i]});
        MODE_TEMPERATURE,
        MODE_COLORIZE:    tv[i] = (40'(gain_p[i]) + 40'(HALF)) >>> FRAC_BITS;
        MODE_CONTRAST:    tv[i] = ((40'(con_p[i]) + 40'(HALF)) >>> FRAC_BITS)
                                  + 40'(HALF) + 40'($signed(cfg.brightness));
        default:          tv[i] = 40'($signed(src[i]));
      endcase
      sv[i]          = sat_chan(tv[i]);
      res_next.t[i]  = sv[i].v;
      res_next.sat   = res_next.sat | sv[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cgt_grad.sv =====
// Two-tap gradient map: tap interpolation on the channel sum through a
// restoring divider, one quotient bit per stage. Depends on cgt_pkg.
`default_nettype none

module cgt_grad import cgt_pkg::*; (
  input  wire logic clk,
  input  wire logic en,
  input  wire rgb_t src,
  input  wire cfg_t cfg,
  output tres_t     res
);

  // first stage: numerator and denominator shared by the channels
  logic signed [17:0] s_sum;
  logic [17:0]        l3;
  logic signed [16:0] ldiff;
  logic signed [19:0] num_next;
  logic signed [18:0] den_next;
  logic signed [19:0] num;
  logic signed [18:0] den;

  always_comb begin
    s_sum    = 18'($signed(src[0])) + 18'($signed(src[1])) + 18'($signed(src[2]));
    l3       = 18'(cfg.tap_levels[31:16]) * 18'd3;
    ldiff    = $signed({1'b0, cfg.tap_levels[31:16]}) - $signed({1'b0, cfg.tap_levels[15:0]});
    num_next = $signed({2'b00, l3}) - 20'(s_sum);
    den_next = 19'(ldiff) * 19'sd3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= num_next;
      den <= den_next;
    end
  end

  // second stage: product and magnitudes
  logic signed [16:0] dcol [3];
  logic signed [36:0] prod [3];
  logic [35:0]        pmag [3];
  logic               pneg [3];
  logic [17:0]        dmag;
  logic               dz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dcol[i] = $signed({1'b0, cfg.color_a[16*i +: 16]}) -
                $signed({1'b0, cfg.color_b[16*i +: 16]});
      prod[i] = 37'(dcol[i]) * 37'(num);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pmag[i] <= prod[i][36] ? 36'(-prod[i]) : prod[i][35:0];
        pneg[i] <= prod[i][36] ^ den[18];
      end
      dmag <= den[18] ? 18'(-den) : den[17:0];
      dz   <= (den == '0);
    end
  end

  // third stage: rounding bias and range check, then the divider stages
  logic [35:0]          dv_rem  [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] dv_q    [DIV_STEPS+1][3];
  logic                 dv_neg  [DIV_STEPS+1][3];
  logic                 dv_ovf  [DIV_STEPS+1][3];
  logic [17:0]          dv_dmag [DIV_STEPS+1];
  logic                 dv_dz   [DIV_STEPS+1];
  logic [35:0]          nsum    [3];
  logic [35:0]          dsub    [DIV_STEPS][3];
  logic                 dge     [DIV_STEPS][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsum[i] = pmag[i] + 36'(dmag >> 1);
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        dsub[j][i] = 36'(dv_dmag[j]) << (DIV_STEPS - 1 - j);
        dge[j][i]  = dv_rem[j][i] >= dsub[j][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= nsum[i];
        dv_q[0][i]   <= '0;
        dv_neg[0][i] <= pneg[i];
        dv_ovf[0][i] <= nsum[i] >= {dmag, {DIV_STEPS{1'b0}}};
      end
      dv_dmag[0] <= dmag;
      dv_dz[0]   <= dz;
      for (int j = 0; j < DIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= dge[j][i] ? dv_rem[j][i] - dsub[j][i] : dv_rem[j][i];
          dv_q[j+1][i]   <= {dv_q[j][i][DIV_STEPS-2:0], dge[j][i]};
          dv_neg[j+1][i] <= dv_neg[j][i];
          dv_ovf[j+1][i] <= dv_ovf[j][i];
        end
        dv_dmag[j+1] <= dv_dmag[j];
        dv_dz[j+1]   <= dv_dz[j];
      end
    end
  end

  // last stage: apply sign, add the second tap, saturate
  tres_t              res_next;
  logic signed [17:0] qs [3];
  logic signed [39:0] tv [3];
  satv_t              sv [3];

  always_comb begin
    res_next.sat = dv_dz[DIV_STEPS];
    for (int i = 0; i < 3; i++) begin
      qs[i] = dv_neg[DIV_STEPS][i] ? -$signed({1'b0, dv_q[DIV_STEPS][i]})
                                   : $signed({1'b0, dv_q[DIV_STEPS][i]});
      if (dv_dz[DIV_STEPS]) begin
        tv[i] = 40'({1'b0, cfg.color_a[16*i +: 16]});
      end else if (dv_ovf[DIV_STEPS][i]) begin
        tv[i] = dv_neg[DIV_STEPS][i] ? -40'sd65536 : 40'sd65536;
      end else begin
        tv[i] = 40'({1'b0, cfg.color_b[16*i +: 16]}) + 40'(qs[i]);
      end
      sv[i]         = sat_chan(tv[i]);
      res_next.t[i] = sv[i].v;
      res_next.sat  = res_next.sat | sv[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cgt_gamma.sv =====
// Gamma power for one channel: log2 by repeated squaring, scale by gamma,
// exp2 by a chain of constant factors, one step per stage. Depends on cgt_pkg.
`default_nettype none

module cgt_gamma import cgt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire chan_t       x,
  input  wire logic [13:0] gamma,
  output chan_t            t,
  output logic             sat
);

  // normalize
  logic [14:0] xm;
  logic [3:0]  e0;
  logic [30:0] y0;

  always_comb begin
    xm = x[14:0];
    e0 = '0;
    for (int b = 0; b < 15; b++) begin
      if (xm[b]) begin
        e0 = 4'(b);
      end
    end
    y0 = 31'(xm) << (5'd30 - 5'(e0));
  end

  // log2 mantissa by squaring
  logic [30:0]         sq_y   [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] sq_lg  [LOG_FRAC+1];
  logic [3:0]          sq_e   [LOG_FRAC+1];
  logic                sq_pos [LOG_FRAC+1];
  logic [61:0]         sq_p   [LOG_FRAC];
  logic [31:0]         sq_hi  [LOG_FRAC];

  always_comb begin
    for (int j = 0; j < LOG_FRAC; j++) begin
      sq_p[j]  = 62'(sq_y[j]) * 62'(sq_y[j]);
      sq_hi[j] = sq_p[j][61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_y[0]   <= y0;
      sq_lg[0]  <= '0;
      sq_e[0]   <= e0;
      sq_pos[0] <= !x[15] && (x != '0);
      for (int j = 0; j < LOG_FRAC; j++) begin
        sq_y[j+1]   <= sq_hi[j][31] ? sq_hi[j][31:1] : sq_hi[j][30:0];
        sq_lg[j+1]  <= {sq_lg[j][LOG_FRAC-2:0], sq_hi[j][31]};
        sq_e[j+1]   <= sq_e[j];
        sq_pos[j+1] <= sq_pos[j];
      end
    end
  end

  // scale the log by gamma, floor to 16 fraction bits
  logic [4:0]         lg_int;
  logic signed [20:0] lg_full;
  logic signed [35:0] p_full;

  always_comb begin
    lg_int  = 5'(sq_e[LOG_FRAC]) - 5'(FRAC_BITS);
    lg_full = $signed({lg_int, sq_lg[LOG_FRAC]});
    p_full  = lg_full * $signed({1'b0, gamma});
  end

  // exp2 of the fraction, most significant factor first
  logic [31:0]         ex_r   [LOG_FRAC+1];
  logic signed [7:0]   ex_n   [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] ex_f   [LOG_FRAC+1];
  logic                ex_pos [LOG_FRAC+1];
  logic                ex_gz  [LOG_FRAC+1];
  logic [63:0]         ex_m   [LOG_FRAC];

  always_comb begin
    for (int j = 0; j < LOG_FRAC; j++) begin
      ex_m[j] = 64'(ex_r[j]) * 64'(EXP_TBL[(LOG_FRAC-1-j)*32 +: 32]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r[0]   <= 32'd1 << 30;
      ex_n[0]   <= p_full[35:28];
      ex_f[0]   <= p_full[27:12];
      ex_pos[0] <= sq_pos[LOG_FRAC];
      ex_gz[0]  <= (gamma == '0);
      for (int j = 0; j < LOG_FRAC; j++) begin
        ex_r[j+1]   <= ex_f[j][LOG_FRAC-1-j] ? ex_m[j][61:30] : ex_r[j];
        ex_n[j+1]   <= ex_n[j];
        ex_f[j+1]   <= ex_f[j];
        ex_pos[j+1] <= ex_pos[j];
        ex_gz[j+1]  <= ex_gz[j];
      end
    end
  end

  // shift by the integer part and round to Q.12
  logic signed [8:0] s;
  logic [4:0]        sh;
  logic [32:0]       v;

  always_comb begin
    s  = $signed(9'(30 - FRAC_BITS)) - 9'(ex_n[LOG_FRAC]);
    sh = s[4:0];
    if (!ex_pos[LOG_FRAC]) begin
      v = ex_gz[LOG_FRAC] ? 33'(ONE) : '0;
    end else if (s <= 9'sd0) begin
      v = 33'd32768;
    end else if (s >= 9'sd32) begin
      v = '0;
    end else begin
      v = (33'(ex_r[LOG_FRAC]) + (33'd1 << (sh - 5'd1))) >> sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= (v > 33'd32767);
      t   <= (v > 33'd32767) ? 16'sh7fff : v[15:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cgt_blend.sv =====
// Two-stage blend of source and transformed color by the amount, with rounding.
// Depends on cgt_pkg for types and the saturation helper.
`default_nettype none

module cgt_blend import cgt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire rgb_t        src,
  input  wire tres_t       xf,
  input  wire logic [12:0] amount,
  output rgb_t             o,
  output logic             sat
);

  logic [12:0]        w;
  logic [12:0]        iw;
  logic signed [29:0] ps_next [3];
  logic signed [29:0] pt_next [3];
  logic signed [29:0] ps      [3];
  logic signed [29:0] pt      [3];
  logic               sat_b1;

  always_comb begin
    w  = (amount > 13'(ONE)) ? 13'(ONE) : amount;
    iw = 13'(ONE) - w;
    for (int i = 0; i < 3; i++) begin
      ps_next[i] = $signed(src[i]) * $signed({1'b0, iw});
      pt_next[i] = $signed(xf.t[i]) * $signed({1'b0, w});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps     <= ps_next;
      pt     <= pt_next;
      sat_b1 <= xf.sat;
    end
  end

  logic signed [39:0] sum [3];
  satv_t              sv  [3];
  rgb_t               o_next;
  logic               sat_next;

  always_comb begin
    sat_next = sat_b1;
    for (int i = 0; i < 3; i++) begin
      sum[i]    = (40'(ps[i]) + 40'(pt[i]) + 40'(HALF)) >>> FRAC_BITS;
      sv[i]     = sat_chan(sum[i]);
      o_next[i] = sv[i].v;
      sat_next  = sat_next | sv[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o   <= o_next;
      sat <= sat_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cgt_checker.sv =====
// Port-level checks for the color grade texel transform, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module cgt_port_assert (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_red,
  input wire logic [15:0] out_green,
  input wire logic [15:0] out_blue,
  input wire logic        saturated,
  input wire logic        pready
);

  // the pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input is held back only by a waiting, stalled result
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) &&
                               $stable(out_blue) && $stable(saturated))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("config port not ready");

endmodule

bind color_grade_texel_transform_unit cgt_port_assert u_cgt_port_assert (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .saturated (saturated),
  .pready    (pready)
);

`default_nettype wire
